[sv/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths for the modular exponentiation block and its checker.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // datapath and field width (base, exponent, modulus, result)
    localparam int DW       = 32;
    localparam int CNT_W    = $clog2(DW);
    localparam int S_DATA_W = ((3 * DW + 7) / 8) * 8;
    localparam int M_DATA_W = ((DW + 7) / 8) * 8;

endpackage

[sv/modular_exponentiation.sv]
// Sequence: a zero modulus or zero exponent goes from accept to the finishing
//   state and then the output register; otherwise base reduction, then a square
//   per exponent bit and a multiply per set exponent bit, then the finishing state.
// Flow: one item at a time; the shared shift-add-reduce unit does one
//   multiplier bit per cycle. Input accepted only when idle.
// Reset: synchronous, active low; clears sequencer and output valid.
// ----------------------------------------------------------------------------
// modular_exponentiation
// MSB-first square and multiply; every modular product is an interleaved
// shift-and-add, one bit per cycle, through a single add/reduce unit.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // base [31:0], exponent [63:32], modulus [95:64]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // power_result [31:0]
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // bad_modulus [0]
    output logic                o_m_axis_tuser
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DW - 1);

    logic [2:0]       r_state;
    logic [DW-1:0]    r_acc;
    logic [DW-1:0]    r_x;
    logic [DW-1:0]    r_y;
    logic [DW-1:0]    r_base;
    logic [DW-1:0]    r_exp;
    logic [DW-1:0]    r_mod;
    logic [DW-1:0]    r_res;
    logic             r_bad;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_ebit;
    logic             r_out_valid;
    logic [DW-1:0]    r_out_data;
    logic             r_out_bad;

    logic [DW-1:0]    n_acc;
    logic [DW-1:0]    addend;
    logic [DW+1:0]    sum;
    logic [DW+2:0]    diff1;
    logic [DW+2:0]    diff2;
    logic             in_acc;
    logic [DW-1:0]    in_base;
    logic [DW-1:0]    in_exp;
    logic [DW-1:0]    in_mod;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_base         = i_s_axis_tdata[DW-1:0];
    assign in_exp          = i_s_axis_tdata[2*DW-1:DW];
    assign in_mod          = i_s_axis_tdata[3*DW-1:2*DW];

    // acc <- (2*acc + addend) mod n; operands below n so sum < 3n
    always_comb begin
        if (r_state == S_RED) begin
            addend = DW'(r_y[DW-1]);
        end else begin
            addend = r_y[DW-1] ? r_x : '0;
        end
        sum   = {1'b0, r_acc, 1'b0} + {2'b00, addend};
        diff1 = {1'b0, sum} - {3'b000, r_mod};
        diff2 = {1'b0, sum} - {2'b00, r_mod, 1'b0};
        if (!diff2[DW+2]) begin
            n_acc = diff2[DW-1:0];
        end else if (!diff1[DW+2]) begin
            n_acc = diff1[DW-1:0];
        end else begin
            n_acc = sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // the finishing state reloads the output register itself
            if (r_out_valid && i_m_axis_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_exp  <= in_exp;
                        r_mod  <= in_mod;
                        r_acc  <= '0;
                        r_y    <= in_base;
                        r_cnt  <= CNT_MAX;
                        r_ebit <= CNT_MAX;
                        if (in_mod == '0) begin
                            r_res   <= '0;
                            r_bad   <= 1'b1;
                            r_state <= S_FIN;
                        end else if (in_exp == '0) begin
                            r_res   <= DW'(1);
                            r_bad   <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (r_cnt == '0) begin
                        // base reduced; partial result starts at 1 mod n
                        r_base  <= n_acc;
                        r_acc   <= '0;
                        r_x     <= (r_mod == DW'(1)) ? '0 : DW'(1);
                        r_y     <= (r_mod == DW'(1)) ? '0 : DW'(1);
                        r_cnt   <= CNT_MAX;
                        r_state <= S_SQ;
                    end else begin
                        r_acc <= n_acc;
                        r_y   <= r_y << 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SQ, S_MUL: begin
                    if (r_cnt == '0) begin
                        r_acc <= '0;
                        r_x   <= n_acc;
                        r_cnt <= CNT_MAX;
                        if (r_state == S_SQ && r_exp[DW-1]) begin
                            r_y     <= r_base;
                            r_state <= S_MUL;
                        end else begin
                            r_exp  <= r_exp << 1;
                            r_ebit <= r_ebit - 1'b1;
                            r_y    <= n_acc;
                            if (r_ebit == '0) begin
                                r_res   <= n_acc;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_SQ;
                            end
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_y   <= r_y << 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_bad   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_DATA_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_bad;

endmodule

[sv/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for modular_exponentiation, bound into each of its instances.
// ----------------------------------------------------------------------------
module mexp_checker
    import mexp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic                o_m_axis_tuser
);

    // one item in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready straight after accept");

    // a bad modulus always yields a zero result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("bad modulus with non-zero result");

    // a result never turns valid straight after an accept made while the output was empty
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid)
        |=> !o_m_axis_tvalid)
        else $error("result valid one cycle after accept");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result dropped or changed");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation. Each item sent in is scored
// against a square-and-multiply computed here with 64-bit arithmetic. Results
// are compared in order. Both stream sides idle at random in two of three phases.
// ----------------------------------------------------------------------------
module testbench;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 11;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 40;
    localparam int RAND_ITEMS  = 88;   // per phase
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DW-1:0] power;
        logic          bad_modulus;
    } t_power_expect;

    class power_scoreboard;
        t_power_expect pending_powers[$];
        int            items_in;
        int            results_out;
        int            zero_mod_items;
        int            zero_exp_items;
        int            errors;

        function new();
            items_in       = 0;
            results_out    = 0;
            zero_mod_items = 0;
            zero_exp_items = 0;
            errors         = 0;
        endfunction

        // base^exp mod n, most significant exponent bit first
        function t_power_expect predict_power(logic [DW-1:0] b, logic [DW-1:0] e,
                                              logic [DW-1:0] n);
            t_power_expect     res;
            longint unsigned   acc;
            longint unsigned   bb;
            longint unsigned   nn;
            int                i;
            res.power       = '0;
            res.bad_modulus = 1'b0;
            if (n == '0) begin
                res.bad_modulus = 1'b1;
                return res;
            end
            if (e == '0) begin
                res.power = DW'(1);
                return res;
            end
            nn  = n;
            bb  = b % nn;
            acc = 1 % nn;
            for (i = DW - 1; i >= 0; i--) begin
                acc = (acc * acc) % nn;
                if (e[i])
                    acc = (acc * bb) % nn;
            end
            res.power = acc[DW-1:0];
            return res;
        endfunction

        function void note_item(logic [DW-1:0] b, logic [DW-1:0] e, logic [DW-1:0] n);
            items_in++;
            if (n == '0)
                zero_mod_items++;
            else if (e == '0)
                zero_exp_items++;
            pending_powers.push_back(predict_power(b, e, n));
        endfunction

        function void check_result(logic [DW-1:0] power, logic bad_modulus);
            t_power_expect want;
            results_out++;
            if (pending_powers.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result %0d with nothing pending: power=%h bad=%b",
                             results_out, power, bad_modulus);
                return;
            end
            want = pending_powers.pop_front();
            if (want.power !== power || want.bad_modulus !== bad_modulus) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result %0d: expected power=%h bad=%b, got power=%h bad=%b",
                             results_out, want.power, want.bad_modulus, power, bad_modulus);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata;   // base, exponent, modulus
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [M_DATA_W-1:0] o_m_axis_tdata;   // power_result
    logic                o_m_axis_tuser;   // bad_modulus

    power_scoreboard sb;
    int              src_idle_pct;
    int              sink_idle_pct;
    int              quiet_cycles = 0;

    modular_exponentiation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // monitors and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_item(i_s_axis_tdata[DW-1:0], i_s_axis_tdata[2*DW-1:DW],
                         i_s_axis_tdata[3*DW-1:2*DW]);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata[DW-1:0], o_m_axis_tuser);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [DW-1:0] b, input logic [DW-1:0] e,
                             input logic [DW-1:0] n);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_DATA_W - 3 * DW){1'b0}}, n, e, b};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_random_item();
        logic [DW-1:0] b;
        logic [DW-1:0] e;
        logic [DW-1:0] n;
        int            sel;
        sel = $urandom_range(15);
        case (sel)
            0:       n = '0;
            1:       n = DW'(1);
            2, 3:    n = $urandom_range(255, 2);
            4:       n = ($urandom_range(1) != 0) ? '1 : 32'h8000_0000;
            default: n = $urandom;
        endcase
        sel = $urandom_range(15);
        case (sel)
            0:       e = '0;
            1, 2:    e = $urandom_range(15, 1);
            3:       e = '1;
            default: e = $urandom;
        endcase
        sel = $urandom_range(15);
        case (sel)
            0:       b = '0;
            1:       b = n;               // base equal to modulus reduces to zero
            2:       b = '1;
            default: b = $urandom;
        endcase
        send_item(b, e, n);
    endtask

    initial begin
        int ph;
        int k;
        sb              = new();
        src_idle_pct    = 14;
        sink_idle_pct   = 54;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_item(32'd0, 32'd0, 32'd0);                     // zero modulus with zero exponent
        send_item(32'd5, 32'd3, 32'd0);                     // zero modulus
        send_item('1, '1, 32'd0);
        send_item(32'd7, 32'd0, 32'd1);                     // zero exponent, modulus one: 1
        send_item(32'd0, 32'd0, 32'd5);                     // 0^0
        send_item(32'd7, 32'd5, 32'd1);                     // modulus one
        send_item(32'd0, 32'd5, 32'd7);
        send_item(32'd100, 32'd3, 32'd7);                   // base above modulus
        send_item(32'd2, 32'd10, 32'd1000);
        send_item(32'd1, '1, 32'd13);
        send_item('1, 32'd1, 32'd2);
        send_item('1, '1, '1);
        send_item('1, '1, 32'hFFFF_FFFE);
        send_item(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
        send_item(32'h1234_5678, '1, 32'h8000_0000);
        send_item(32'd2, 32'd31, '1);
        send_item(32'hFFFF_FFFA, 32'h5555_5555, 32'hFFFF_FFFB);
        send_item(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h7FFF_FFFF);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 14;
                    sink_idle_pct = 54;
                end
                1: begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 14;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (k = 0; k < RAND_ITEMS; k++)
                send_random_item();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_powers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d items (%0d zero modulus, %0d zero exponent), %0d results checked",
                 sb.items_in, sb.zero_mod_items, sb.zero_exp_items, sb.results_out);
        $display("Idling phases: source-heavy, sink-heavy, none; %0d errors", sb.errors);
        if (sb.errors == 0 && sb.pending_powers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mexp_pkg.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
sim/testbench.sv
